// File: src/cpwh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpwh_pkg
// Shared widths, reset values, letter codes and the control struct of the
// Cyrillic polynomial word hash.
// ----------------------------------------------------------------------------
package cpwh_pkg;

    localparam int ACC_W  = 64;
    localparam int BASE_W = 32;
    localparam int BKT_W  = 25;
    localparam int CODE_W = 6;
    localparam int CNT_W  = $clog2(ACC_W);

    localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(37);
    localparam logic [BKT_W-1:0]  BKT_RST  = BKT_W'(1048576);

    localparam logic [CODE_W-1:0] CODE_FIRST      = CODE_W'(1);
    localparam logic [CODE_W-1:0] CODE_SMALL_YO   = CODE_W'(33);
    localparam logic [CODE_W-1:0] CODE_CAPITAL_YO = CODE_W'(34);
    localparam logic [CODE_W-1:0] CODE_REJECT     = CODE_W'(35);

    // Control of the multiply-accumulate unit.
    typedef struct packed {
        logic start;
        logic clear;
    } t_mac_ctrl;

    // Maps one code-page byte to its letter code, or to the reject code.
    function automatic logic [CODE_W-1:0] letter_code(input logic [7:0] b);
        logic [CODE_W-1:0] code;
        code = CODE_REJECT;
        if (b >= 8'hE0) begin
            code = CODE_W'(b - 8'hE0) + CODE_FIRST;
        end else if (b >= 8'hC0) begin
            code = CODE_W'(b - 8'hC0) + CODE_FIRST;
        end else if (b == 8'hB8 || b == 8'h2D) begin
            code = CODE_SMALL_YO;
        end else if (b == 8'hA8) begin
            code = CODE_CAPITAL_YO;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// File: src/cpwh_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpwh_mac
// Accumulator with one shared 32x32 multiplier: adds a letter code, then
// multiplies the 64-bit accumulator by the base in two halves.
// ----------------------------------------------------------------------------
module cpwh_mac
    import cpwh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mac_ctrl         i_ctrl,
    input  wire logic [CODE_W-1:0] i_code,
    input  wire logic [BASE_W-1:0] i_base,
    output logic                   o_done,
    output logic [ACC_W-1:0]       o_acc
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;

    localparam int HALF_W = ACC_W / 2;

    logic [1:0]          r_phase, n_phase;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [ACC_W-1:0]    r_prod, n_prod;
    logic [HALF_W-1:0]   mul_a;
    logic [ACC_W-1:0]    mul_p;

    // The single multiplier: low half of the accumulator first, high half next.
    assign mul_a = (r_phase == PH_LO) ? r_acc[HALF_W-1:0] : r_acc[ACC_W-1:HALF_W];
    assign mul_p = ACC_W'(mul_a) * ACC_W'(i_base);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_prod  = r_prod;
        case (r_phase)
            PH_IDLE: begin
                if (i_ctrl.clear) begin
                    n_acc = '0;
                end else if (i_ctrl.start) begin
                    n_acc   = r_acc + ACC_W'(i_code);
                    n_phase = PH_LO;
                end
            end
            PH_LO: begin
                n_prod  = mul_p;
                n_phase = PH_HI;
            end
            PH_HI: begin
                // Only the low half of the high partial product survives mod 2^64.
                n_acc   = r_prod + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
        r_prod <= n_prod;
    end

    assign o_done = (r_phase == PH_HI);
    assign o_acc  = r_acc;

endmodule
`default_nettype wire

// File: src/cpwh_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpwh_mod
// Restoring remainder unit: one dividend bit per cycle through a shared
// compare and subtract.
// ----------------------------------------------------------------------------
module cpwh_mod
    import cpwh_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [ACC_W-1:0] i_dividend,
    input  wire logic [BKT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [BKT_W-1:0]      o_rem
);

    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ACC_W-1:0]  r_dvd, n_dvd;
    logic [BKT_W-1:0]  r_rem, n_rem;
    logic [BKT_W:0]    trial;

    assign trial = {r_rem, r_dvd[ACC_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        if (r_busy) begin
            n_dvd = {r_dvd[ACC_W-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = BKT_W'(trial - {1'b0, i_divisor});
            end else begin
                n_rem = trial[BKT_W-1:0];
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ACC_W - 1);
            n_dvd  = i_dividend;
            n_rem  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// File: src/cyrillic_polynomial_word_hash_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cyrillic_polynomial_word_hash_top
// Polynomial hash of Cyrillic words, one code-page byte per transfer.
// ----------------------------------------------------------------------------
// An accepted letter adds its code, then takes the low and high halves of the
// accumulator through the shared 32x32 multiplier. A rejected byte marks the
// word invalid. At word end a valid word goes through the bit-serial remainder
// unit, then loads the result register; an invalid word skips the remainder.
// Reset (synchronous, active low) restores base 37, bucket count 1048576,
// clears the accumulator and the invalid flag and empties the result register.
// ----------------------------------------------------------------------------
module cyrillic_polynomial_word_hash_top
    import cpwh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Character input channel.
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_char_code,
    input  wire logic              i_word_end,
    // Result output channel.
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [BKT_W-1:0]       o_bucket,
    output logic                   o_bad_word,
    // Register port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a character transfer
    localparam logic [2:0] ST_MAC  = 3'd1;  // multiply-accumulate in progress
    localparam logic [2:0] ST_DGO  = 3'd2;  // accumulator settled, start remainder
    localparam logic [2:0] ST_DIV  = 3'd3;  // remainder in progress
    localparam logic [2:0] ST_OUT  = 3'd4;  // hand the result to the output register

    logic [2:0]         r_state, n_state;
    logic [BASE_W-1:0]  r_base;
    logic [BKT_W-1:0]   r_bkt;
    logic               r_bad, n_bad;
    logic               r_last, n_last;
    logic               r_out_valid, n_out_valid;
    logic [BKT_W-1:0]   r_bucket, n_bucket;
    logic               r_bad_word, n_bad_word;

    logic               in_xfer;
    logic               cfg_wr;
    logic [CODE_W-1:0]  code;
    t_mac_ctrl          mac_ctrl;
    logic               mac_done;
    logic [ACC_W-1:0]   acc;
    logic               div_start;
    logic               div_done;
    logic [BKT_W-1:0]   rem;

    // ------------------------------------------------------------------
    // Register port. Every access completes at once; the register index is
    // taken from address bit 2, so the two registers sit at 0x0 and 0x4.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RST;
            r_bkt  <= BKT_RST;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_bkt <= pwdata[BKT_W-1:0];
            end else begin
                r_base <= pwdata[BASE_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? 32'(r_bkt) : r_base;

    // ------------------------------------------------------------------
    // Sequencer. The block takes one character at a time; a letter starts
    // the multiply-accumulate unit, any other byte only marks the word bad.
    // At word end a good word goes through the remainder unit, and the
    // result then waits until the output register is free.
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign code       = letter_code(i_char_code);

    always_comb begin
        n_state        = r_state;
        n_bad          = r_bad;
        n_last         = r_last;
        n_out_valid    = r_out_valid;
        n_bucket       = r_bucket;
        n_bad_word     = r_bad_word;
        mac_ctrl.start = 1'b0;
        mac_ctrl.clear = 1'b0;
        div_start      = 1'b0;

        // The output register empties on its own transfer.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_last = i_word_end;
                    if (code != CODE_REJECT) begin
                        mac_ctrl.start = 1'b1;
                        n_state        = ST_MAC;
                    end else begin
                        n_bad = 1'b1;
                        if (i_word_end) begin
                            n_state = ST_OUT;
                        end
                    end
                end
            end
            ST_MAC: begin
                if (mac_done) begin
                    if (!r_last) begin
                        n_state = ST_IDLE;
                    end else if (r_bad) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_DGO;
                    end
                end
            end
            ST_DGO: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_bad_word  = r_bad;
                    // A bad word reports the bucket count itself; a zero
                    // bucket count leaves a good word in bucket zero.
                    if (r_bad) begin
                        n_bucket = r_bkt;
                    end else if (r_bkt == '0) begin
                        n_bucket = '0;
                    end else begin
                        n_bucket = rem;
                    end
                    mac_ctrl.clear = 1'b1;
                    n_bad          = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bad       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bad       <= n_bad;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_bucket   <= n_bucket;
        r_bad_word <= n_bad_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_bucket    = r_bucket;
    assign o_bad_word  = r_bad_word;

    // ------------------------------------------------------------------
    // Datapath units.
    // ------------------------------------------------------------------
    cpwh_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_code  (code),
        .i_base  (r_base),
        .o_done  (mac_done),
        .o_acc   (acc)
    );

    cpwh_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (acc),
        .i_divisor  (r_bkt),
        .o_done     (div_done),
        .o_rem      (rem)
    );

endmodule
`default_nettype wire
